[design/boct_pkg.sv]
// Shared types, field widths and event codes for the box overlap contact tracker.
package boct_pkg;

  localparam int unsigned ID_BITS_DEF = 6;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned SIZE_W      = 15;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_t;

  // Members run from the highest bits down, so x lands in the lowest bits of a box slice.
  typedef struct packed {
    logic [SIZE_W-1:0]       h;
    logic [SIZE_W-1:0]       w;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } box_t;

endpackage

[design/boct_box_test.sv]
// Exact axis-aligned box overlap test on centres and full sizes.
module boct_box_test (
  input  boct_pkg::box_t left_box,
  input  boct_pkg::box_t right_box,
  output logic           overlap
);
  import boct_pkg::*;

  logic signed [POS_W:0] dx;
  logic signed [POS_W:0] dy;
  logic [POS_W:0]        adx;
  logic [POS_W:0]        ady;
  logic [SIZE_W:0]       sum_w;
  logic [SIZE_W:0]       sum_h;
  logic                  x_ok;
  logic                  y_ok;

  assign dx    = {right_box.x[POS_W-1], right_box.x} - {left_box.x[POS_W-1], left_box.x};
  assign dy    = {right_box.y[POS_W-1], right_box.y} - {left_box.y[POS_W-1], left_box.y};
  assign adx   = dx[POS_W] ? (~dx + 1'b1) : dx;
  assign ady   = dy[POS_W] ? (~dy + 1'b1) : dy;
  assign sum_w = {1'b0, left_box.w} + {1'b0, right_box.w};
  assign sum_h = {1'b0, left_box.h} + {1'b0, right_box.h};

  // Twice the centre distance is compared against the summed full sizes.
  assign x_ok    = {adx, 1'b0} <= {{(POS_W-SIZE_W+1){1'b0}}, sum_w};
  assign y_ok    = {ady, 1'b0} <= {{(POS_W-SIZE_W+1){1'b0}}, sum_h};
  assign overlap = x_ok && y_ok;

endmodule

[design/box_overlap_contact_tracker_unit.sv]
// Top level of the box overlap contact tracker: pair stage, contact table and result register.
//
// Each input transaction carries one ordered collider pair: two IDs, two boxes given as
// signed centres and unsigned full sizes, and a dead flag per object in in_tuser. Each
// input transaction yields exactly one output transaction with the contact event
// (none, enter, stay, exit) and the geometric overlap flag.
// A contact bit is kept for each ordered ID pair in a single-port-write memory of
// 2^(2*ID_BITS) entries (4096 at the default). The table is read when a pair is accepted
// and written back when the pair leaves the pair stage; a write that lands on the pair
// just read is forwarded.
// An accepted pair passes through the pair stage and then the result register before out_tvalid,
// and one pair is accepted in every cycle while the output side keeps up.
// After reset a clearing pass writes zero to every table entry, one entry a cycle, and
// in_tready stays low until the pass has cleared all 2^(2*ID_BITS) entries (4096 at the default).
// When out_tready is low, the result register holds its transaction, one more pair can
// still be taken into the pair stage, and in_tready then drops until the output moves.
module box_overlap_contact_tracker_unit #(
  parameter int unsigned ID_BITS = boct_pkg::ID_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // left_id, right_id, left_x, left_y, left_w, left_h, right_x, right_y, right_w, right_h
  input  logic [((2*ID_BITS+124+7)/8)*8-1:0]           in_tdata,
  // left_dead, right_dead
  input  logic [1:0]                                   in_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // contact_event, boxes_overlap
  output logic [boct_pkg::OUT_TDATA_W-1:0]             out_tdata
);
  import boct_pkg::*;

  localparam int unsigned PAIR_W = 2 * ID_BITS;
  localparam int unsigned PAIRS  = 1 << PAIR_W;
  localparam int unsigned BOX_W  = 2 * POS_W + 2 * SIZE_W;
  localparam int unsigned LB_LO  = PAIR_W;
  localparam int unsigned RB_LO  = PAIR_W + BOX_W;

  logic                 clearing_r;
  logic [PAIR_W-1:0]    clr_addr_r;

  logic                 s1_vld_r;
  logic [ID_BITS-1:0]   s1_lid_r;
  logic [ID_BITS-1:0]   s1_rid_r;
  box_t                 s1_lbox_r;
  box_t                 s1_rbox_r;
  logic                 s1_dead_r;
  logic                 rd_bit_r;
  logic                 fwd_hit_r;
  logic                 fwd_bit_r;

  logic                 out_vld_r;
  contact_event_t       out_event_r;
  logic                 out_ovl_r;

  logic                 contact_mem [PAIRS];

  logic                 in_acc;
  logic                 s1_adv;
  logic [ID_BITS-1:0]   in_lid;
  logic [ID_BITS-1:0]   in_rid;
  logic [PAIR_W-1:0]    in_addr;
  logic [PAIR_W-1:0]    s1_addr;
  box_t                 in_lbox;
  box_t                 in_rbox;
  logic                 ovl;
  logic                 had;
  logic                 item_we;
  logic                 new_bit;
  contact_event_t       event_nxt;
  logic                 mem_we;
  logic [PAIR_W-1:0]    mem_waddr;
  logic                 mem_wdata;

  assign in_lid  = in_tdata[ID_BITS-1:0];
  assign in_rid  = in_tdata[PAIR_W-1:ID_BITS];
  assign in_lbox = box_t'(in_tdata[LB_LO +: BOX_W]);
  assign in_rbox = box_t'(in_tdata[RB_LO +: BOX_W]);
  assign in_addr = {in_lid, in_rid};
  assign s1_addr = {s1_lid_r, s1_rid_r};

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !clearing_r && (!s1_vld_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  boct_box_test u_box_test (
    .left_box  (s1_lbox_r),
    .right_box (s1_rbox_r),
    .overlap   (ovl)
  );

  assign had = fwd_hit_r ? fwd_bit_r : rd_bit_r;

  always_comb begin
    event_nxt = EV_NONE;
    new_bit   = had;
    if (s1_lid_r != s1_rid_r) begin
      if (ovl) begin
        if (had) begin
          if (s1_dead_r) begin
            event_nxt = EV_EXIT;
            new_bit   = 1'b0;
          end else begin
            event_nxt = EV_STAY;
          end
        end else if (!s1_dead_r) begin
          event_nxt = EV_ENTER;
          new_bit   = 1'b1;
        end
      end else if (had) begin
        event_nxt = EV_EXIT;
        new_bit   = 1'b0;
      end
    end
  end

  assign item_we   = s1_adv && (s1_lid_r != s1_rid_r);
  assign mem_we    = clearing_r || item_we;
  assign mem_waddr = clearing_r ? clr_addr_r : s1_addr;
  assign mem_wdata = clearing_r ? 1'b0 : new_bit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      contact_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_bit_r <= contact_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  // The table write of the departing pair and the read of the arriving pair share an edge.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_lid_r  <= in_lid;
      s1_rid_r  <= in_rid;
      s1_lbox_r <= in_lbox;
      s1_rbox_r <= in_rbox;
      s1_dead_r <= in_tuser[0] || in_tuser[1];
      fwd_hit_r <= item_we && (s1_addr == in_addr);
      fwd_bit_r <= new_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event_r <= event_nxt;
      out_ovl_r   <= ovl;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-3){1'b0}}, out_ovl_r, out_event_r};

  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (!rst_n) clearing_r |-> !in_tready
  ) else $error("input accepted during the table clearing pass");

  a_enter_needs_overlap : assert property (
    @(posedge clk) disable iff (!rst_n)
    (s1_adv && (event_nxt == EV_ENTER || event_nxt == EV_STAY)) |-> ovl
  ) else $error("enter or stay reported without overlap");

  a_accept_fills_stage : assert property (
    @(posedge clk) disable iff (!rst_n) in_acc |=> s1_vld_r
  ) else $error("accepted pair did not reach the pair stage");

  a_result_follows_stage : assert property (
    @(posedge clk) disable iff (!rst_n) s1_adv |=> out_vld_r
  ) else $error("pair stage advanced without loading the result register");

  a_equal_ids_no_event : assert property (
    @(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_lid_r == s1_rid_r) |-> (event_nxt == EV_NONE && !item_we)
  ) else $error("pair with equal IDs produced an event or a table write");

endmodule

[tb/box_overlap_contact_tracker_unit_tb.sv]
// Self-checking testbench for the box overlap contact tracker with predictor, driver and monitor.
`timescale 1ns / 100ps

module box_overlap_contact_tracker_unit_tb;
  import boct_pkg::*;

  localparam int unsigned ID_W = 6;
  localparam int unsigned IN_W = ((2*ID_W+124+7)/8)*8;
  localparam int unsigned RAND_ITEMS = 780;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLDOFF_CYCLES = 300;

  typedef struct {
    logic [ID_W-1:0]         lid;
    logic [ID_W-1:0]         rid;
    logic signed [POS_W-1:0] lx;
    logic signed [POS_W-1:0] ly;
    logic [SIZE_W-1:0]       lw;
    logic [SIZE_W-1:0]       lh;
    logic signed [POS_W-1:0] rx;
    logic signed [POS_W-1:0] ry;
    logic [SIZE_W-1:0]       rw;
    logic [SIZE_W-1:0]       rh;
    logic                    ldead;
    logic                    rdead;
    bit                      drain;
  } pair_item_t;

  typedef struct {
    contact_event_t ev;
    logic           ovl;
  } contact_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = 2'b00;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  pair_item_t pend_q[$];
  pair_item_t cur_pair;
  contact_result_t expected_q[$];
  bit contact_bits [0:(1<<(2*ID_W))-1];

  int unsigned in_acc = 0;
  int unsigned out_acc = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned ev_count [4];
  int unsigned ovl_count = 0;

  box_overlap_contact_tracker_unit #(.ID_BITS(ID_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic bit axis_hit(logic signed [POS_W-1:0] pl, logic signed [POS_W-1:0] pr,
                                  logic [SIZE_W-1:0] sl, logic [SIZE_W-1:0] sr);
    int d;
    d = int'(pr) - int'(pl);
    if (d < 0) d = -d;
    return (2 * d) <= (int'(sl) + int'(sr));
  endfunction

  function automatic contact_result_t track_contact(pair_item_t p);
    contact_result_t r;
    bit dead;
    bit had;
    logic [2*ID_W-1:0] idx;
    dead = p.ldead | p.rdead;
    r.ovl = axis_hit(p.lx, p.rx, p.lw, p.rw) && axis_hit(p.ly, p.ry, p.lh, p.rh);
    r.ev = EV_NONE;
    if (p.lid != p.rid) begin
      idx = {p.lid, p.rid};
      had = contact_bits[idx];
      if (r.ovl) begin
        if (had && dead) begin
          r.ev = EV_EXIT;
          contact_bits[idx] = 1'b0;
        end else if (had) begin
          r.ev = EV_STAY;
        end else if (!dead) begin
          r.ev = EV_ENTER;
          contact_bits[idx] = 1'b1;
        end
      end else if (had) begin
        r.ev = EV_EXIT;
        contact_bits[idx] = 1'b0;
      end
    end
    ev_count[r.ev]++;
    if (r.ovl) ovl_count++;
    return r;
  endfunction

  function automatic pair_item_t mk_pair(int lid, int rid, int lx, int ly, int lw, int lh,
                                         int rx, int ry, int rw, int rh, bit ld, bit rd);
    pair_item_t p;
    p.lid = ID_W'(lid); p.rid = ID_W'(rid);
    p.lx = POS_W'(lx); p.ly = POS_W'(ly); p.lw = SIZE_W'(lw); p.lh = SIZE_W'(lh);
    p.rx = POS_W'(rx); p.ry = POS_W'(ry); p.rw = SIZE_W'(rw); p.rh = SIZE_W'(rh);
    p.ldead = ld; p.rdead = rd;
    p.drain = 1'b0;
    return p;
  endfunction

  function automatic pair_item_t rand_pair();
    pair_item_t p;
    int span;
    if ($urandom_range(99) < 70) begin
      span = $urandom_range(3) == 0 ? 32767 : 2047;
      p.lid = ID_W'($urandom_range(7));
      p.rid = ID_W'($urandom_range(7));
      p.lx = POS_W'($urandom);
      p.ly = POS_W'($urandom);
      p.rx = POS_W'(p.lx + $signed($urandom_range(2*span) - span) / 2);
      p.ry = POS_W'(p.ly + $signed($urandom_range(2*span) - span) / 2);
      p.lw = SIZE_W'($urandom_range(span));
      p.lh = SIZE_W'($urandom_range(span));
      p.rw = SIZE_W'($urandom_range(span));
      p.rh = SIZE_W'($urandom_range(span));
      p.ldead = $urandom_range(9) == 0;
      p.rdead = $urandom_range(9) == 0;
    end else begin
      p.lid = ID_W'($urandom); p.rid = ID_W'($urandom);
      p.lx = POS_W'($urandom); p.ly = POS_W'($urandom);
      p.lw = SIZE_W'($urandom); p.lh = SIZE_W'($urandom);
      p.rx = POS_W'($urandom); p.ry = POS_W'($urandom);
      p.rw = SIZE_W'($urandom); p.rh = SIZE_W'($urandom);
      p.ldead = 1'($urandom); p.rdead = 1'($urandom);
    end
    p.drain = 1'b0;
    return p;
  endfunction

  // Driver: holds a transaction until it is taken, then feeds the next pending pair.
  always @(posedge clk) begin
    bit taken;
    bit calm;
    if (rst_n) begin
      taken = in_tvalid && in_tready;
      if (taken) begin
        expected_q.push_back(track_contact(cur_pair));
        in_acc <= in_acc + 1;
      end
      calm = (in_acc >= 300) && (in_acc < 460);
      if (!in_tvalid || taken) begin
        if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 37) &&
            (!pend_q[0].drain || (in_acc + taken) == out_acc)) begin
          cur_pair = pend_q.pop_front();
          in_tdata <= {cur_pair.rh, cur_pair.rw, cur_pair.ry, cur_pair.rx,
                       cur_pair.lh, cur_pair.lw, cur_pair.ly, cur_pair.lx,
                       cur_pair.rid, cur_pair.lid};
          in_tuser <= {cur_pair.rdead, cur_pair.ldead};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transaction with the oldest prediction.
  always @(posedge clk) begin
    contact_result_t e;
    bit calm;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_acc <= out_acc + 1;
        if (expected_q.size() == 0) begin
          $error("contact result arrived with no prediction pending: out_tdata=%h", out_tdata);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[1:0] !== e.ev) begin
            $error("contact_event: expected %0d, actual %0d", e.ev, out_tdata[1:0]);
            err_cnt++;
          end
          if (out_tdata[2] !== e.ovl) begin
            $error("boxes_overlap: expected %0d, actual %0d", e.ovl, out_tdata[2]);
            err_cnt++;
          end
        end
      end
      calm = (out_acc >= 300) && (out_acc < 460);
      if (!hold_done && out_acc >= 480) begin
        hold_done <= 1'b1;
        hold_left <= HOLDOFF_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out with %0d pairs pending and %0d results outstanding.",
               pend_q.size(), expected_q.size());
      $display("box_overlap_contact_tracker_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pair_item_t p;
    int unsigned total_items;
    foreach (contact_bits[i]) contact_bits[i] = 1'b0;
    // Zero-size boxes on one centre, then stay, left dead exit, dead overlap without contact.
    pend_q.push_back(mk_pair(0, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_pair(0, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_pair(0, 63, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    pend_q.push_back(mk_pair(0, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    pend_q.push_back(mk_pair(0, 63, 100, 100, 20, 20, 110, 90, 0, 0, 0, 0));
    // The reverse ordered pair keeps its own contact bit.
    pend_q.push_back(mk_pair(63, 0, 100, 100, 20, 20, 110, 90, 0, 0, 0, 0));
    pend_q.push_back(mk_pair(0, 63, 100, 100, 20, 20, 111, 90, 0, 0, 0, 0));
    pend_q.push_back(mk_pair(63, 0, 100, 100, 20, 20, 110, 90, 0, 0, 1, 1));
    pend_q.push_back(mk_pair(0, 63, 100, 100, 20, 20, 111, 90, 0, 0, 0, 0));
    pend_q.push_back(mk_pair(0, 63, 100, 100, 21, 20, 110, 90, 0, 0, 0, 0));
    pend_q.push_back(mk_pair(0, 63, 100, 100, 21, 20, 100, 111, 0, 0, 0, 0));
    // Equal IDs report the overlap but never an event.
    pend_q.push_back(mk_pair(5, 5, 0, 0, 10, 10, 0, 0, 10, 10, 0, 0));
    pend_q.push_back(mk_pair(63, 63, -32768, -32768, 32767, 32767, 32767, 32767,
                             32767, 32767, 1, 1));
    pend_q.push_back(mk_pair(1, 2, -32768, 0, 32767, 0, 0, 0, 32767, 0, 0, 0));
    pend_q.push_back(mk_pair(1, 2, -16384, -16384, 32767, 32767, 16383, 16383,
                             32767, 32767, 0, 0));
    pend_q.push_back(mk_pair(1, 2, -16384, -16384, 32767, 32767, 16383, 16383,
                             32767, 32767, 0, 0));
    pend_q.push_back(mk_pair(1, 2, 32767, 32767, 32767, 32767, -32768, -32768,
                             32767, 32767, 1, 1));
    pend_q.push_back(mk_pair(2, 1, 32767, -32768, 0, 0, 32767, -32768, 0, 0, 0, 0));
    pend_q.push_back(mk_pair(2, 1, 32767, -32768, 0, 0, 32767, -32767, 0, 0, 1, 1));
    pend_q.push_back(mk_pair(62, 1, 0, 0, 0, 0, 1, 1, 2, 2, 0, 0));
    pend_q.push_back(mk_pair(62, 1, 0, 0, 0, 0, 1, 1, 2, 2, 0, 1));
    for (int i = 0; i < RAND_ITEMS; i++) begin
      p = rand_pair();
      if (i == 0 || i == 600) p.drain = 1'b1;
      pend_q.push_back(p);
    end
    total_items = pend_q.size();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (out_acc < total_items) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Checked %0d pair transactions: %0d enter, %0d stay, %0d exit, %0d none.",
             in_acc, ev_count[EV_ENTER], ev_count[EV_STAY], ev_count[EV_EXIT],
             ev_count[EV_NONE]);
    $display("Boxes overlapped in %0d of them, with a long output stall and a full drain.",
             ovl_count);
    if (err_cnt == 0) begin
      $display("box_overlap_contact_tracker_unit regression: pass");
    end else begin
      $display("box_overlap_contact_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule
